>>> rtl/core/sha1_pkg.sv
package sha1_pkg;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // one classified item handed from front to back
    typedef struct packed {
        logic       finish;
        logic [7:0] data;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_ADD,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/core/sha1_front.sv
// Input stage and job queue.
module sha1_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_command,
    input  logic [7:0]        in_data,
    output logic              job_valid,
    input  logic              job_ready,
    output sha1_pkg::job_t    job
);

    sha1_pkg::job_t               q_mem [sha1_pkg::QUEUE_DEPTH];
    logic [sha1_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [sha1_pkg::QPTR_W:0]    count_reg;
    logic                         push, pop;

    assign in_ready  = (count_reg != (sha1_pkg::QPTR_W+1)'(sha1_pkg::QUEUE_DEPTH));
    assign job_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;
    assign job       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg].finish <= (in_command == sha1_pkg::CMD_FINISH);
            q_mem[wr_ptr_reg].data   <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + {{sha1_pkg::QPTR_W{1'b0}}, push}
                                   - {{sha1_pkg::QPTR_W{1'b0}}, pop};
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (sha1_pkg::QPTR_W+1)'(sha1_pkg::QUEUE_DEPTH))
        else $error("queue overflow");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count slip");
    a_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointer mismatch");
`endif

endmodule

>>> rtl/core/sha1_back.sv
// Byte packing, padding, round engine and digest output.
module sha1_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  sha1_pkg::job_t    job,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_word,
    output logic [2:0]        out_index,
    output logic              out_last
);

    sha1_pkg::state_t state_reg, state_next;

    logic [31:0] chain_reg [5];
    logic [31:0] w_reg [16];
    logic [5:0]  bcnt_reg;
    logic [63:0] bits_reg;
    logic [63:0] len_reg;
    logic [2:0]  lcnt_reg;
    logic [6:0]  rnd_reg;
    logic [2:0]  widx_reg;
    logic        fin_reg;   // compression belongs to a finish
    logic        post_reg;  // state after compression: 0 idle, 1 padding
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;

    // byte push control
    logic        push;
    logic [7:0]  push_byte;
    logic [3:0]  slot;
    logic        start_comp;

    logic [31:0] f, k, t, wn;

    assign slot = bcnt_reg[5:2];

    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = sha1_pkg::K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1_pkg::K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = sha1_pkg::K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1_pkg::K3;
        end
        t  = {a_reg[26:0], a_reg[31:27]} + f + e_reg + w_reg[0] + k;
        wn = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        wn = {wn[30:0], wn[31]};
    end

    always_comb
    begin
        state_next = state_reg;
        job_ready  = 1'b0;
        push       = 1'b0;
        push_byte  = '0;
        unique case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    push      = 1'b1;
                    push_byte = job.finish ? sha1_pkg::PAD_BYTE : job.data;
                end
            end
            sha1_pkg::ST_PAD:
            begin
                push = (bcnt_reg != 6'd56);
            end
            sha1_pkg::ST_LEN:
            begin
                push      = 1'b1;
                push_byte = len_reg[63:56];
            end
            default: ;
        endcase
        start_comp = push && (bcnt_reg == 6'd63);
        unique case (state_reg)
            sha1_pkg::ST_IDLE:
                if (job_valid)
                begin
                    if (start_comp)
                        state_next = sha1_pkg::ST_COMP;
                    else if (job.finish)
                        state_next = sha1_pkg::ST_PAD;
                end
            sha1_pkg::ST_PAD:
                if (start_comp)
                    state_next = sha1_pkg::ST_COMP;
                else if (bcnt_reg == 6'd56)
                    state_next = sha1_pkg::ST_LEN;
            sha1_pkg::ST_LEN:
                if (start_comp)
                    state_next = sha1_pkg::ST_COMP;
            sha1_pkg::ST_COMP:
                if (rnd_reg == 7'd79)
                    state_next = sha1_pkg::ST_ADD;
            sha1_pkg::ST_ADD:
                if (fin_reg)
                    state_next = sha1_pkg::ST_EMIT;
                else if (post_reg)
                    state_next = sha1_pkg::ST_PAD;
                else
                    state_next = sha1_pkg::ST_IDLE;
            sha1_pkg::ST_EMIT:
                if (out_ready && widx_reg == 3'd4)
                    state_next = sha1_pkg::ST_IDLE;
            default:
                state_next = sha1_pkg::ST_IDLE;
        endcase
    end

    assign out_valid = (state_reg == sha1_pkg::ST_EMIT);
    assign out_word  = chain_reg[widx_reg];
    assign out_index = widx_reg;
    assign out_last  = (widx_reg == 3'd4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha1_pkg::ST_IDLE;
            chain_reg[0] <= sha1_pkg::IV0;
            chain_reg[1] <= sha1_pkg::IV1;
            chain_reg[2] <= sha1_pkg::IV2;
            chain_reg[3] <= sha1_pkg::IV3;
            chain_reg[4] <= sha1_pkg::IV4;
            for (int i = 0; i < 16; i++)
                w_reg[i] <= '0;
            bcnt_reg <= '0;
            bits_reg <= '0;
            len_reg  <= '0;
            lcnt_reg <= '0;
            rnd_reg  <= '0;
            widx_reg <= '0;
            fin_reg  <= 1'b0;
            post_reg <= 1'b0;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0; e_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
            begin
                w_reg[slot] <= {w_reg[slot][23:0], push_byte};
                bcnt_reg    <= bcnt_reg + 1'b1;
            end
            if (state_reg == sha1_pkg::ST_IDLE && job_valid)
            begin
                if (job.finish)
                begin
                    len_reg  <= bits_reg;
                    lcnt_reg <= '0;
                    fin_reg  <= 1'b0;
                    post_reg <= 1'b1;
                end
                else
                begin
                    bits_reg <= bits_reg + 64'd8;
                    post_reg <= 1'b0;
                end
            end
            if (state_reg == sha1_pkg::ST_LEN)
            begin
                len_reg  <= {len_reg[55:0], 8'h00};
                lcnt_reg <= lcnt_reg + 1'b1;
                if (lcnt_reg == 3'd7)
                    fin_reg <= 1'b1;
            end
            if (start_comp)
            begin
                rnd_reg <= '0;
                a_reg <= chain_reg[0];
                b_reg <= chain_reg[1];
                c_reg <= chain_reg[2];
                d_reg <= chain_reg[3];
                e_reg <= chain_reg[4];
            end
            if (state_reg == sha1_pkg::ST_COMP)
            begin
                // rolling 16-word schedule window
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i+1];
                w_reg[15] <= wn;
                rnd_reg <= rnd_reg + 1'b1;
                e_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= {b_reg[1:0], b_reg[31:2]};
                b_reg <= a_reg;
                a_reg <= t;
            end
            if (state_reg == sha1_pkg::ST_ADD)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
                for (int i = 0; i < 16; i++)
                    w_reg[i] <= '0;
                widx_reg <= '0;
            end
            if (state_reg == sha1_pkg::ST_EMIT && out_ready)
            begin
                widx_reg <= widx_reg + 1'b1;
                if (widx_reg == 3'd4)
                begin
                    chain_reg[0] <= sha1_pkg::IV0;
                    chain_reg[1] <= sha1_pkg::IV1;
                    chain_reg[2] <= sha1_pkg::IV2;
                    chain_reg[3] <= sha1_pkg::IV3;
                    chain_reg[4] <= sha1_pkg::IV4;
                    bits_reg <= '0;
                    fin_reg  <= 1'b0;
                    post_reg <= 1'b0;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1_pkg::ST_COMP) |-> (rnd_reg < 7'd80))
        else $error("round counter out of range");
    a_emit_zero_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1_pkg::ST_EMIT) |-> (bcnt_reg == 6'd0))
        else $error("digest with partial block");
    a_comp_block_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == sha1_pkg::ST_COMP) |-> (bcnt_reg == 6'd0))
        else $error("compression without full block");
`endif

endmodule

>>> rtl/core/sha1_hash_stream_unit.sv
// SHA-1 hash over a byte stream.
// Slave channel s_axis_*: one item per message byte (tuser = 0, tdata = byte)
// or a finish command (tuser = 1, tdata ignored).
// Master channel m_axis_*: after a finish, five items H0..H4; tdata carries
// the digest word, tuser the word index, tlast marks H4.
// An append byte is packed into the current block; every 64th byte starts
// the 80-round compression (one round per cycle) and the chaining add,
// during which the back end takes no new byte.
// A finish pushes padding and length bytes, runs one or two compressions,
// then five output items, one per cycle while m_axis_tready is high.
// A two-entry queue decouples input from the compression engine, so bytes
// are still taken while a block compresses, until the queue fills.
// Reset (rst_n low, asynchronous) loads the initial vector, clears the block
// and the bit count. When the receiver stalls, the current digest item holds
// and the back end waits; input keeps filling the queue.
module sha1_hash_stream_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    sha1_pkg::job_t job;
    logic           job_valid, job_ready;

    sha1_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_command (s_axis_tuser),
        .in_data    (s_axis_tdata),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job)
    );

    sha1_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (m_axis_tdata),
        .out_index (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

>>> verif/testbench.sv
module testbench;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    sha1_hash_stream_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    msg_item_t    pending_items[$];
    digest_item_t expected_digests[$];

    // predictor state
    logic [31:0] hash_chain[5];
    logic [31:0] hash_block[16];
    logic [5:0]  hash_fill;
    logic [63:0] hash_bits;

    int  mismatches;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_off_cycles;
    bit  stim_done;
    bit  send_pause;
    bit  in_taken;
    longint cycle_count;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic hash_reset();
        hash_chain[0] = sha1_pkg::IV0;
        hash_chain[1] = sha1_pkg::IV1;
        hash_chain[2] = sha1_pkg::IV2;
        hash_chain[3] = sha1_pkg::IV3;
        hash_chain[4] = sha1_pkg::IV4;
        foreach (hash_block[i])
            hash_block[i] = '0;
        hash_fill = '0;
        hash_bits = '0;
    endtask

    task automatic hash_compress();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++)
            w[r] = hash_block[r];
        for (int r = 16; r < 80; r++)
            w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2];
        d = hash_chain[3]; e = hash_chain[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d); k = sha1_pkg::K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d; k = sha1_pkg::K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2;
            end
            else
            begin
                f = b ^ c ^ d; k = sha1_pkg::K3;
            end
            t = rotl(a, 5) + f + e + w[r] + k;
            e = d; d = c; c = rotl(b, 30); b = a; a = t;
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c;
        hash_chain[3] += d; hash_chain[4] += e;
    endtask

    task automatic hash_push(input logic [7:0] byte_in);
        hash_block[hash_fill[5:2]] = {hash_block[hash_fill[5:2]][23:0], byte_in};
        hash_fill = hash_fill + 1'b1;
        if (hash_fill == 0)
            hash_compress();
    endtask

    // expected digest words for one accepted item
    task automatic hash_predict(input msg_item_t it);
        logic [63:0] len;
        digest_item_t d;
        if (it.cmd == sha1_pkg::CMD_APPEND)
        begin
            hash_push(it.data);
            hash_bits = hash_bits + 64'd8;
        end
        else
        begin
            len = hash_bits;
            hash_push(sha1_pkg::PAD_BYTE);
            while (hash_fill != 6'd56)
                hash_push(8'h00);
            for (int i = 7; i >= 0; i--)
                hash_push(len[8*i +: 8]);
            for (int i = 0; i < 5; i++)
            begin
                d.word  = hash_chain[i];
                d.index = 3'(i);
                d.last  = (i == 4);
                expected_digests.push_back(d);
            end
            hash_reset();
        end
    endtask

    task automatic add_message(input int len);
        msg_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it.cmd  = sha1_pkg::CMD_APPEND;
            it.data = 8'($urandom_range(0, 255));
            pending_items.push_back(it);
        end
        it.cmd  = sha1_pkg::CMD_FINISH;
        it.data = 8'($urandom_range(0, 255));
        pending_items.push_back(it);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return $urandom_range(52, 68);   // around the padding boundary
        if (r < 8)
            return $urandom_range(0, 20);
        return $urandom_range(0, 140);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // input accept: predict at the accepting edge
    always @(posedge clk)
    begin
        in_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken)
            hash_predict(pending_items.pop_front());
    end

    // driver: offers queued items, holds tvalid and data until accepted
    always @(negedge clk)
    begin
        if (rst_n && s_axis_tvalid && !in_taken)
            s_axis_tvalid <= 1'b1;
        else if (rst_n && !send_pause && pending_items.size() > 0
            && ($urandom_range(0, 99) >= send_idle_pct))
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= pending_items[0].cmd;
            s_axis_tdata  <= pending_items[0].data;
        end
        else
            s_axis_tvalid <= 1'b0;
        m_axis_tready <= rst_n && hold_off_cycles == 0
                         && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // receiver hold-off counter
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
            hold_off_cycles <= hold_off_cycles - 1;
    end

    // monitor
    always @(posedge clk)
    begin
        digest_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_digests.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest item %h idx %0d last %b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = expected_digests.pop_front();
                if (m_axis_tdata !== want.word || m_axis_tuser !== want.index
                    || m_axis_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 want.word, want.index, want.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    task automatic drain_inputs();
        while (pending_items.size() > 0 || s_axis_tvalid)
            @(posedge clk);
    endtask

    task automatic wait_results();
        while (expected_digests.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        msg_item_t it;
        int phase_items;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = 1'b0;
        m_axis_tready   = 1'b0;
        mismatches      = 0;
        hold_off_cycles = 0;
        send_pause      = 1'b0;
        stim_done       = 1'b0;
        send_idle_pct   = 13;
        recv_idle_pct   = 57;
        hash_reset();
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, field extremes, a short message
        add_message(0);
        it.cmd = sha1_pkg::CMD_APPEND; it.data = 8'h00; pending_items.push_back(it);
        it.data = 8'hFF; pending_items.push_back(it);
        it.data = 8'hA5; pending_items.push_back(it);
        it.cmd = sha1_pkg::CMD_FINISH; it.data = 8'hFF; pending_items.push_back(it);
        add_message(0);
        add_message(15);
        drain_inputs();
        wait_results();
        // 56 bytes: padding spills into a second block
        add_message(56);
        add_message(55);
        add_message(64);
        // long receiver hold-off while the sender keeps offering
        hold_off_cycles = 400;
        drain_inputs();
        wait_results();

        // sender pause until everything is out
        send_pause = 1'b1;
        wait_results();
        repeat (20) @(posedge clk);
        send_pause = 1'b0;

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                send_idle_pct = 57; recv_idle_pct = 13;
            end
            else if (ph == 2)
            begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            phase_items = 0;
            while (phase_items < 75)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    // a stray finish without preceding bytes
                    add_message(0);
                    phase_items++;
                end
                else
                begin
                    int n;
                    n = pick_len();
                    add_message(n);
                    phase_items += n + 1;
                end
                drain_inputs();
                if ($urandom_range(0, 7) == 0)
                    hold_off_cycles = $urandom_range(50, 300);
            end
        end

        drain_inputs();
        stim_done = 1'b1;
        wait_results();
        repeat (500) @(posedge clk);
        if (mismatches == 0 && expected_digests.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

>>> sha1_hash_stream_unit.f
rtl/core/sha1_pkg.sv
rtl/core/sha1_front.sv
rtl/core/sha1_back.sv
rtl/core/sha1_hash_stream_unit.sv
verif/testbench.sv
